### src/cau_pkg.sv
// ----------------------------------------------------------------------------
// cau_pkg
// Shared codes and the side record that travels down the divider chain.
// ----------------------------------------------------------------------------
`default_nettype none

package cau_pkg;

    localparam int FIELD_BITS = 16;

    // operation codes carried in tuser
    localparam logic [1:0] K_SUB = 2'd0;
    localparam logic [1:0] K_MUL = 2'd1;
    localparam logic [1:0] K_DIV = 2'd2;

    // per-item data that rides alongside the division cells
    typedef struct packed {
        logic [1:0]            kind;
        logic [FIELD_BITS-1:0] res_re;   // subtract or multiply result
        logic [FIELD_BITS-1:0] res_im;
        logic                  ovf;      // subtract or multiply overflow
        logic                  dz;       // zero divisor
        logic [1:0]            neg;      // quotient sign, im in bit 1
        logic [1:0]            big;      // quotient beyond the word range
    } t_side;

endpackage

`default_nettype wire

### src/cau_div_cell.sv
// ----------------------------------------------------------------------------
// cau_div_cell
// One restoring division step for the real and imaginary lanes.
// ----------------------------------------------------------------------------
`default_nettype none

module cau_div_cell #(
    parameter int DW = 32,
    parameter int QW = 16
) (
    input  wire                         i_clk,
    input  wire                         i_en,
    input  wire  [1:0][DW-1:0]          i_rem,
    input  wire  [1:0][QW-1:0]          i_low,
    input  wire  [1:0][QW-1:0]          i_q,
    input  wire  [DW-1:0]               i_d,
    input  wire  cau_pkg::t_side        i_side,
    output logic [1:0][DW-1:0]          o_rem,
    output logic [1:0][QW-1:0]          o_low,
    output logic [1:0][QW-1:0]          o_q,
    output logic [DW-1:0]               o_d,
    output cau_pkg::t_side              o_side
);

    logic [1:0][DW-1:0] n_rem;
    logic [1:0][QW-1:0] n_low;
    logic [1:0][QW-1:0] n_q;

    always_comb begin
        logic [DW:0] t;
        logic        ge;
        for (int l = 0; l < 2; l++) begin
            t  = {i_rem[l], i_low[l][QW-1]};
            ge = (t >= {1'b0, i_d});
            if (ge) begin
                t = t - {1'b0, i_d};
            end
            n_rem[l] = t[DW-1:0];
            n_low[l] = {i_low[l][QW-2:0], 1'b0};
            n_q[l]   = {i_q[l][QW-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_rem  <= n_rem;
            o_low  <= n_low;
            o_q    <= n_q;
            o_d    <= i_d;
            o_side <= i_side;
        end
    end

endmodule

`default_nettype wire

### src/complex_arith_unit.sv
// ----------------------------------------------------------------------------
// complex_arith_unit
// Complex subtract, multiply and divide on signed fixed point operands.
// ----------------------------------------------------------------------------
// channel  dir  tdata                            tuser
// s_axis   in   a_re, a_im, b_re, b_im (16 each) kind (2)
// m_axis   out  res_re, res_im (16 each)         overflow, div_by_zero
//
// one item per cycle while m_axis is not stalled; the path is three front stages,
// one divider cell per quotient bit and one output register
// every operation passes the full chain so items stay in order
// reset clears only the valid bits; a stall on m_axis freezes the whole chain
// ----------------------------------------------------------------------------
`default_nettype none

module complex_arith_unit #(
    parameter int FRAC_BITS = 8,
    parameter int WORD_BITS = 16
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [63:0] s_axis_tdata,   // a_re, a_im, b_re, b_im
    input  wire  [1:0]  s_axis_tuser,   // kind
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [31:0] m_axis_tdata,   // res_re, res_im
    output logic [1:0]  m_axis_tuser    // overflow, div_by_zero
);

    localparam int FB  = cau_pkg::FIELD_BITS;
    localparam int EFF = (WORD_BITS < FB) ? WORD_BITS : FB;
    localparam int F   = FRAC_BITS;
    localparam int PW  = 2 * EFF;
    localparam int SW  = PW + 1;
    localparam int NW  = SW + F;
    localparam int DW  = PW;
    localparam int RW  = NW - EFF;
    localparam int NST = EFF + 3;

    localparam logic signed [SW-1:0] SAT_HI = SW'((2 ** (EFF - 1)) - 1);
    localparam logic signed [SW-1:0] SAT_LO = -SAT_HI - SW'(1);

    logic           en;
    logic [NST-1:0] r_vld;
    logic           r_out_vld;

    assign en            = !r_out_vld || m_axis_tready;
    assign s_axis_tready = en;

    function automatic logic [EFF:0] sat_w(input logic signed [SW-1:0] v);
        // returns {ovf, value}
        if (v > SAT_HI) begin
            return {1'b1, SAT_HI[EFF-1:0]};
        end else if (v < SAT_LO) begin
            return {1'b1, SAT_LO[EFF-1:0]};
        end
        return {1'b0, v[EFF-1:0]};
    endfunction

    function automatic logic signed [SW-1:0] rescale(input logic signed [SW-1:0] v);
        logic [SW-1:0] mag;
        mag = v[SW-1] ? SW'(-v) : SW'(v);
        mag = mag >> F;
        return v[SW-1] ? $signed(SW'(-mag)) : $signed(mag);
    endfunction

    // stage 1: operands, products, differences
    logic signed [EFF-1:0] ar, ai, br, bi;
    assign ar = s_axis_tdata[EFF-1:0];
    assign ai = s_axis_tdata[16+EFF-1:16];
    assign br = s_axis_tdata[32+EFF-1:32];
    assign bi = s_axis_tdata[48+EFF-1:48];

    logic [1:0]           r1_kind;
    logic signed [EFF:0]  r1_dre, r1_dim;
    logic signed [PW-1:0] r1_rr, r1_ii, r1_ri, r1_ir, r1_bb, r1_cc;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_kind <= s_axis_tuser;
            r1_dre  <= (EFF+1)'(ar) - (EFF+1)'(br);
            r1_dim  <= (EFF+1)'(ai) - (EFF+1)'(bi);
            r1_rr   <= ar * br;
            r1_ii   <= ai * bi;
            r1_ri   <= ar * bi;
            r1_ir   <= ai * br;
            r1_bb   <= br * br;
            r1_cc   <= bi * bi;
        end
    end

    // stage 2: sums, subtract and multiply results
    logic signed [SW-1:0] s_rr, s_ii, s_ri, s_ir, m_re, m_im;
    logic [EFF:0]         sr_re, sr_im;
    logic [1:0]           r2_kind;
    logic [EFF-1:0]       r2_re, r2_im;
    logic                 r2_ovf;
    logic signed [SW-1:0] r2_nre, r2_nim;
    logic [DW-1:0]        r2_d;

    assign s_rr = SW'(r1_rr);
    assign s_ii = SW'(r1_ii);
    assign s_ri = SW'(r1_ri);
    assign s_ir = SW'(r1_ir);
    assign m_re = rescale(s_rr - s_ii);
    assign m_im = rescale(s_ri + s_ir);

    always_comb begin
        if (r1_kind == cau_pkg::K_SUB) begin
            sr_re = sat_w(SW'(r1_dre));
            sr_im = sat_w(SW'(r1_dim));
        end else begin
            sr_re = sat_w(m_re);
            sr_im = sat_w(m_im);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_kind <= r1_kind;
            r2_re   <= sr_re[EFF-1:0];
            r2_im   <= sr_im[EFF-1:0];
            r2_ovf  <= sr_re[EFF] | sr_im[EFF];
            r2_nre  <= s_rr + s_ii;
            r2_nim  <= s_ir - s_ri;
            r2_d    <= DW'($unsigned(r1_bb)) + DW'($unsigned(r1_cc));
        end
    end

    // stage 3: magnitudes, range check, divider seed
    logic [1:0][DW-1:0]  c_rem  [0:EFF];
    logic [1:0][EFF-1:0] c_low  [0:EFF];
    logic [1:0][EFF-1:0] c_q    [0:EFF];
    logic [DW-1:0]       c_d    [0:EFF];
    cau_pkg::t_side      c_side [0:EFF];

    logic [1:0][DW-1:0]  n_rem;
    logic [1:0][EFF-1:0] n_low;
    cau_pkg::t_side      n_side;

    always_comb begin
        logic [SW-1:0]      mag;
        logic [NW-1:0]      nmag;
        logic [DW+RW-1:0]   hi_part;
        logic signed [SW-1:0] nv;
        n_side.kind   = r2_kind;
        n_side.res_re = FB'($signed(r2_re));
        n_side.res_im = FB'($signed(r2_im));
        n_side.ovf    = r2_ovf;
        n_side.dz     = (r2_d == '0);
        for (int l = 0; l < 2; l++) begin
            nv   = (l == 0) ? r2_nre : r2_nim;
            mag  = nv[SW-1] ? SW'(-nv) : SW'(nv);
            nmag = {mag, {F{1'b0}}};
            hi_part = {{DW{1'b0}}, nmag[NW-1:EFF]};
            n_side.neg[l] = nv[SW-1];
            n_side.big[l] = (hi_part >= {{RW{1'b0}}, r2_d});
            n_rem[l] = hi_part[DW-1:0];
            n_low[l] = nmag[EFF-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            c_rem[0]  <= n_rem;
            c_low[0]  <= n_low;
            c_q[0]    <= '0;
            c_d[0]    <= r2_d;
            c_side[0] <= n_side;
        end
    end

    // divider chain, one quotient bit per cell
    for (genvar g = 0; g < EFF; g++) begin : g_cell
        cau_div_cell #(
            .DW (DW),
            .QW (EFF)
        ) u_cell (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_rem  (c_rem[g]),
            .i_low  (c_low[g]),
            .i_q    (c_q[g]),
            .i_d    (c_d[g]),
            .i_side (c_side[g]),
            .o_rem  (c_rem[g+1]),
            .o_low  (c_low[g+1]),
            .o_q    (c_q[g+1]),
            .o_d    (c_d[g+1]),
            .o_side (c_side[g+1])
        );
    end

    // output stage: quotient saturation and operation select
    cau_pkg::t_side  fs;
    logic [1:0][EFF-1:0] dq;
    logic [1:0]      dovf;
    logic [FB-1:0]   n_re, n_im;
    logic [1:0]      n_user;

    assign fs = c_side[EFF];

    always_comb begin
        logic [EFF-1:0] q;
        for (int l = 0; l < 2; l++) begin
            q = c_q[EFF][l];
            dovf[l] = 1'b0;
            if (fs.neg[l]) begin
                if (fs.big[l] || (q[EFF-1] && (|q[EFF-2:0]))) begin
                    dovf[l] = 1'b1;
                    dq[l]   = SAT_LO[EFF-1:0];
                end else begin
                    dq[l] = EFF'(-q);
                end
            end else begin
                if (fs.big[l] || q[EFF-1]) begin
                    dovf[l] = 1'b1;
                    dq[l]   = SAT_HI[EFF-1:0];
                end else begin
                    dq[l] = q;
                end
            end
        end
        case (fs.kind)
            cau_pkg::K_SUB, cau_pkg::K_MUL: begin
                n_re   = fs.res_re;
                n_im   = fs.res_im;
                n_user = {1'b0, fs.ovf};
            end
            cau_pkg::K_DIV: begin
                if (fs.dz) begin
                    n_re   = '0;
                    n_im   = '0;
                    n_user = 2'b10;
                end else begin
                    n_re   = FB'($signed(dq[0]));
                    n_im   = FB'($signed(dq[1]));
                    n_user = {1'b0, dovf[0] | dovf[1]};
                end
            end
            default: begin
                n_re   = '0;
                n_im   = '0;
                n_user = 2'b00;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            m_axis_tdata <= {n_im, n_re};
            m_axis_tuser <= n_user;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_vld     <= {r_vld[NST-2:0], s_axis_tvalid};
            r_out_vld <= r_vld[NST-1];
        end
    end

    assign m_axis_tvalid = r_out_vld;

endmodule

`default_nettype wire
